### design/csvt_pkg.sv
`default_nettype none

package csvt_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned KindW        = 2;
  localparam int unsigned IndexW       = 4;
  localparam int unsigned LimitW       = 5;
  localparam int unsigned DefMaxFields = 16;

  localparam logic [LimitW-1:0] FieldLimitRst = LimitW'(12);

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_DONE   = 3'd4
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [IndexW-1:0] field_index;
    logic              line_end;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

`default_nettype wire

### design/csvt_if.sv
`default_nettype none

interface csvt_in_if;
  logic                        valid;
  logic                        ready;
  logic [csvt_pkg::ByteW-1:0]  byte_in;
  logic                        line_start;

  modport source (output valid, output byte_in, output line_start, input ready);
  modport sink (input valid, input byte_in, input line_start, output ready);
endinterface

interface csvt_out_if;
  logic                        valid;
  logic                        ready;
  logic [csvt_pkg::KindW-1:0]  kind;
  logic [csvt_pkg::ByteW-1:0]  data_byte;
  logic [csvt_pkg::IndexW-1:0] field_index;
  logic                        line_end;

  modport source (
    output valid, output kind, output data_byte, output field_index, output line_end,
    input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input field_index, input line_end,
    output ready
  );
endinterface

`default_nettype wire

### design/csvt_parse.sv
`default_nettype none

module csvt_parse #(
  parameter int unsigned MAX_FIELDS = csvt_pkg::DefMaxFields
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [csvt_pkg::ByteW-1:0]   byte_i,
  input  wire logic                         line_start_i,
  input  wire logic [csvt_pkg::LimitW-1:0]  field_limit_i,
  output      csvt_pkg::parse_out_t         parse_o
);
  import csvt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FIELDS);

  mode_e            mode_q, mode_d, mode_cur;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_cur;
  logic             term, is_quote, is_comma, want_emit;
  logic [CmpW-1:0]  cnt_ext, lim_ext;
  kind_e            kind;
  logic [ByteW-1:0] data;
  logic             le;

  always_comb begin
    mode_cur = line_start_i ? MODE_START : mode_q;
    cnt_cur  = line_start_i ? '0 : cnt_q;
    term     = (byte_i == ChNul) || (byte_i == ChLf) || (byte_i == ChCr);
    is_quote = (byte_i == ChQuote);
    is_comma = (byte_i == ChComma);

    mode_d    = mode_cur;
    cnt_d     = cnt_cur;
    want_emit = 1'b0;
    kind      = KIND_DATA;
    data      = '0;
    le        = 1'b0;

    if (mode_cur == MODE_DONE) begin
      // rest of the line is dropped
    end else if (term) begin
      want_emit = 1'b1;
      kind      = (mode_cur == MODE_START) ? KIND_LINE_END : KIND_FIELD_END;
      le        = 1'b1;
      mode_d    = MODE_DONE;
    end else begin
      case (mode_cur)
        MODE_START: begin
          if (is_quote) begin
            mode_d = MODE_QUOTED;
          end else if (is_comma) begin
            want_emit = 1'b1;
            kind      = KIND_FIELD_END;
          end else begin
            want_emit = 1'b1;
            data      = byte_i;
            mode_d    = MODE_PLAIN;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            mode_d = MODE_QSEEN;
          end else begin
            want_emit = 1'b1;
            data      = byte_i;
          end
        end
        MODE_QSEEN: begin
          if (is_quote) begin
            // doubled quote
            want_emit = 1'b1;
            data      = byte_i;
            mode_d    = MODE_QUOTED;
          end else if (is_comma) begin
            want_emit = 1'b1;
            kind      = KIND_FIELD_END;
          end else begin
            want_emit = 1'b1;
            data      = byte_i;
            mode_d    = MODE_PLAIN;
          end
        end
        default: begin
          want_emit = 1'b1;
          if (is_comma) begin
            kind = KIND_FIELD_END;
          end else begin
            data   = byte_i;
            mode_d = MODE_PLAIN;
          end
        end
      endcase
      if (is_comma && (mode_cur != MODE_QUOTED)) begin
        mode_d = MODE_START;
        if (cnt_cur != MaxCnt) begin
          cnt_d = cnt_cur + CntW'(1);
        end
      end
    end

    cnt_ext = CmpW'(cnt_cur);
    lim_ext = (CmpW'(field_limit_i) > CmpW'(MAX_FIELDS)) ? CmpW'(MAX_FIELDS)
                                                         : CmpW'(field_limit_i);

    parse_o.emit            = want_emit && (cnt_ext < lim_ext);
    parse_o.res.kind        = kind;
    parse_o.res.data_byte   = data;
    parse_o.res.field_index = cnt_ext[IndexW-1:0];
    parse_o.res.line_end    = le;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/csv_line_tokenizer.sv
// csv_line_tokenizer: splits quoted csv lines into data bytes, field and line ends.
// in_ch_i carries one byte per beat plus a line_start flag on the first byte
// of each line. out_ch_o carries at most one result per input beat: a data
// byte, a field end, or a line end with no open field, tagged with the field
// index and a line_end flag. Fields at or past the field limit are silent.
// cfg_we_i/cfg_wdata_i write the field limit (reset 12); write only when idle.
// Throughput: one byte per cycle unless stalled. Latency: a result appears on
// out_ch_o the cycle after its byte is taken; it is set by the single result
// register behind the parse logic. Bytes that cause no result leave nothing.
// Reset clears the parse mode and field counter (parsing starts at field
// start) and empties the result register.
// A stalled receiver holds the result; in_ch_i.ready follows out_ch_o.ready
// while a result is waiting, so a new byte is taken in the same cycle the
// old result leaves.
`default_nettype none

module csv_line_tokenizer #(
  parameter int unsigned MAX_FIELDS = csvt_pkg::DefMaxFields
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  csvt_in_if.sink                          in_ch_i,
  csvt_out_if.source                       out_ch_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [csvt_pkg::LimitW-1:0] cfg_wdata_i
);
  import csvt_pkg::*;

  logic [LimitW-1:0] field_limit_q;
  logic              accept;
  parse_out_t        parse;
  logic              out_valid_q, out_valid_d;
  result_t           out_res_q;

  assign in_ch_i.ready = !out_valid_q || out_ch_o.ready;
  assign accept        = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit_q <= FieldLimitRst;
    end else if (cfg_we_i) begin
      field_limit_q <= cfg_wdata_i;
    end
  end

  csvt_parse #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (in_ch_i.byte_in),
    .line_start_i (in_ch_i.line_start),
    .field_limit_i(field_limit_q),
    .parse_o      (parse)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && parse.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && parse.emit) begin
      out_res_q <= parse.res;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.kind        = out_res_q.kind;
  assign out_ch_o.data_byte   = out_res_q.data_byte;
  assign out_ch_o.field_index = out_res_q.field_index;
  assign out_ch_o.line_end    = out_res_q.line_end;

`ifndef ASSERT_OFF
  // no byte may be taken while a result is stuck in the register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch_o.ready |-> !in_ch_i.ready)
    else $error("input taken while result stalled");

  a_data_not_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.kind == KIND_DATA) |-> !out_res_q.line_end)
    else $error("data beat flagged as line end");

  a_line_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.kind == KIND_LINE_END) |-> out_res_q.line_end)
    else $error("empty line end without line_end flag");

  a_marker_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.kind != KIND_DATA) |-> (out_res_q.data_byte == '0))
    else $error("marker beat carries a data byte");
`endif

endmodule

`default_nettype wire
